/* hdl/assert_macros.svh */
// assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/nfl_pkg.sv */
package nfl_pkg;

  localparam int TAPS        = 51;
  localparam int FIR_LEN     = 51;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 2;
  localparam int MODE_BITS   = 2;

  // history terms plus the two feedback terms
  localparam int STEPS     = TAPS + 2;
  localparam int IDX_W     = $clog2(STEPS);
  localparam int CNT_W     = $clog2(TAPS + 1);
  localparam int ADDR_W    = $clog2(TAPS);
  localparam int FIR_IDX_W = $clog2(FIR_LEN);
  localparam int PROD_W    = OUT_BITS + COEF_BITS;
  localparam int ACC_W     = PROD_W + 4;

  localparam logic [MODE_BITS-1:0] MODE_NOTCH = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FIR   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_NONE  = 2'd2;

  localparam int NOTCH_UNITY = 1 << FRAC_BITS;
  localparam int NOTCH_C1    = 124657;
  localparam int NOTCH_C2    = 123410;
  localparam int NOTCH_C3    = 64232;

  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);
  localparam int OUT_MAX_INT = (1 << (OUT_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX_INT);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-OUT_MAX_INT - 1);

  localparam int FIR_COEF [FIR_LEN] = '{
    0, 43, 81, 101, 80, 0, -132, -272, -343, -264,
    0, 397, 780, 941, 698, 0, -1003, -1950, -2362, -1789,
    0, 2891, 6400, 9777, 12217, 13107, 12217, 9777, 6400, 2891,
    0, -1789, -2362, -1950, -1003, 0, 698, 941, 780, 397,
    0, -264, -343, -272, -132, 0, 80, 101, 81, 43,
    0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // coefficient for one term of the sum, zero for unused modes
  function automatic logic signed [COEF_BITS-1:0] coef_lookup(
    input logic [MODE_BITS-1:0] mode,
    input logic [IDX_W-1:0]     step
  );
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    case (mode)
      MODE_NOTCH: begin
        if (step == IDX_W'(0) || step == IDX_W'(2)) begin
          c = COEF_BITS'(NOTCH_UNITY);
        end else if (step == IDX_W'(1)) begin
          c = COEF_BITS'(-NOTCH_C1);
        end else if (step == IDX_W'(TAPS)) begin
          c = COEF_BITS'(NOTCH_C2);
        end else if (step == IDX_W'(TAPS + 1)) begin
          c = COEF_BITS'(-NOTCH_C3);
        end
      end
      MODE_FIR: begin
        if (step < IDX_W'(FIR_LEN) && step < IDX_W'(TAPS)) begin
          c = COEF_BITS'(FIR_COEF[step[FIR_IDX_W-1:0]]);
        end
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* hdl/nfl_if.sv */
interface nfl_in_if;
  import nfl_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface nfl_out_if;
  import nfl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface nfl_cfg_if;
  import nfl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_BITS-1:0] filter_mode;
  modport source (output valid, output filter_mode, input ready);
  modport sink (input valid, input filter_mode, output ready);
endinterface

/* hdl/nfl_ram.sv */
module nfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/notch_or_fir_lowpass_filter_top.sv */
// channel  | role   | payload
// smp      | sink   | sample_in, 24-bit signed
// res      | source | sample_out, 26-bit signed, saturated
// cfg      | sink   | filter_mode, 2-bit, always ready
//
// a sample is accepted in idle, then one shared multiply-accumulate takes the 51 history
// entries in the ram and the two feedback terms, one per cycle; the drain state then
// waits for the operand and product registers to empty, and the done state rounds and
// saturates into the output register; smp.ready is high only between samples
// a result waits in its last cycle until the output register is free
// synchronous reset clears mode, output history and fill count; ram needs no clearing
`include "assert_macros.svh"

module notch_or_fir_lowpass_filter_top (
  input logic       clk,
  input logic       rst,
  nfl_in_if.sink    smp,
  nfl_out_if.source res,
  nfl_cfg_if.sink   cfg
);
  import nfl_pkg::*;

  state_t state, state_next;

  logic [IDX_W-1:0]          step;
  logic [ADDR_W-1:0]         head;
  logic [ADDR_W-1:0]         head_wr;
  logic [ADDR_W-1:0]         rd_addr;
  logic [CNT_W-1:0]          fill;
  logic [MODE_BITS-1:0]      filter_mode;
  logic                      s1_valid;
  logic [IDX_W-1:0]          s1_step;
  logic                      p_valid;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [OUT_BITS-1:0] y1;
  logic signed [OUT_BITS-1:0] y2;
  logic                      out_valid;
  logic signed [OUT_BITS-1:0] out_sample;

  logic [SAMPLE_BITS-1:0]     rdata;
  logic signed [OUT_BITS-1:0] opnd;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [ACC_W-1:0]    acc_shr;
  logic signed [OUT_BITS-1:0] y_sat;
  logic                       in_fire;
  logic                       mac_issue;
  logic                       done_fire;
  logic                       in_rdy;

  nfl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_hist (
    .clk   (clk),
    .we    (in_fire),
    .waddr (head_wr),
    .wdata (smp.sample_in),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (smp.valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (step == IDX_W'(STEPS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !p_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_rdy    = 1'b0;
    mac_issue = 1'b0;
    done_fire = 1'b0;
    unique case (state)
      ST_IDLE:  in_rdy = 1'b1;
      ST_MAC:   mac_issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  done_fire = !out_valid || res.ready;
      default:  ;
    endcase
  end

  assign smp.ready      = in_rdy;
  assign in_fire        = smp.valid && in_rdy;
  assign head_wr        = (head == ADDR_W'(TAPS - 1)) ? '0 : head + ADDR_W'(1);
  assign cfg.ready      = 1'b1;
  assign res.valid      = out_valid;
  assign res.sample_out = out_sample;

  // operand select: history entry, zero before it was ever written, or feedback
  always_comb begin
    if (s1_step < IDX_W'(TAPS)) begin
      if (s1_step < IDX_W'(fill)) begin
        opnd = {{(OUT_BITS - SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
      end else begin
        opnd = '0;
      end
    end else if (s1_step == IDX_W'(TAPS)) begin
      opnd = y1;
    end else begin
      opnd = y2;
    end
    coef = coef_lookup(filter_mode, s1_step);
  end

  // round half up, then saturate
  always_comb begin
    acc_rnd = acc + ACC_W'(ROUND_HALF);
    acc_shr = acc_rnd >>> FRAC_BITS;
    if (acc_shr > SAT_HI) begin
      y_sat = SAT_HI[OUT_BITS-1:0];
    end else if (acc_shr < SAT_LO) begin
      y_sat = SAT_LO[OUT_BITS-1:0];
    end else begin
      y_sat = acc_shr[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      head        <= ADDR_W'(TAPS - 1);
      rd_addr     <= '0;
      fill        <= '0;
      filter_mode <= MODE_NOTCH;
      s1_valid    <= 1'b0;
      p_valid     <= 1'b0;
      y1          <= '0;
      y2          <= '0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= mac_issue;
      p_valid  <= s1_valid;
      if (cfg.valid) begin
        filter_mode <= cfg.filter_mode;
      end
      if (in_fire) begin
        head    <= head_wr;
        rd_addr <= head_wr;
        step    <= '0;
        if (fill != CNT_W'(TAPS)) begin
          fill <= fill + CNT_W'(1);
        end
      end else if (mac_issue) begin
        step    <= step + IDX_W'(1);
        rd_addr <= (rd_addr == '0) ? ADDR_W'(TAPS - 1) : rd_addr - ADDR_W'(1);
      end
      if (done_fire) begin
        y1        <= y_sat;
        y2        <= y1;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    s1_step <= step;
    prod    <= opnd * coef;
    if (in_fire) begin
      acc <= '0;
    end else if (p_valid) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (done_fire) begin
      out_sample <= y_sat;
    end
  end

  `ASSERT_SAME(a_idle_empty, smp.ready, !s1_valid && !p_valid, "input taken with mac busy")
  `ASSERT_NEXT(a_start_mac, smp.valid && smp.ready, state == ST_MAC && step == '0, "mac not started")
  `ASSERT_SAME(a_addr_range, 1'b1, rd_addr < ADDR_W'(TAPS) && head < ADDR_W'(TAPS), "ram address out of range")
  `ASSERT_SAME(a_step_range, s1_valid, s1_step < IDX_W'(STEPS), "term index out of range")

endmodule

/* verif/notch_or_fir_lowpass_filter_check.sv */
module notch_or_fir_lowpass_filter_check (
  input  logic clk,
  input  logic rst,
  nfl_in_if    smp,
  nfl_out_if   res,
  nfl_cfg_if   cfg,
  output int   failures,
  output int   outstanding
);
  import nfl_pkg::*;

  localparam int     LOWPASS_LEN = 51;
  localparam longint UNITY       = 65536;
  localparam longint HALF_LSB    = 32768;
  localparam longint NOTCH_ZERO  = 124657;
  localparam longint NOTCH_POLE  = 123410;
  localparam longint NOTCH_DAMP  = 64232;
  localparam longint OUT_HI      = (longint'(1) << (OUT_BITS - 1)) - 1;
  localparam longint OUT_LO      = -OUT_HI - 1;

  localparam int LOWPASS_COEF [LOWPASS_LEN] = '{
    0, 43, 81, 101, 80, 0, -132, -272, -343, -264,
    0, 397, 780, 941, 698, 0, -1003, -1950, -2362, -1789,
    0, 2891, 6400, 9777, 12217, 13107, 12217, 9777, 6400, 2891,
    0, -1789, -2362, -1950, -1003, 0, 698, 941, 780, 397,
    0, -264, -343, -272, -132, 0, 80, 101, 81, 43,
    0
  };

  logic signed [SAMPLE_BITS-1:0] sample_hist [TAPS];
  logic signed [OUT_BITS-1:0]    y1;
  logic signed [OUT_BITS-1:0]    y2;
  logic [MODE_BITS-1:0]          mode;
  logic signed [OUT_BITS-1:0]    predicted_samples [$];
  int                            mismatch_count = 0;
  int                            waiting_count = 0;

  assign failures    = mismatch_count;
  assign outstanding = waiting_count;

  // shifts the new sample in and returns the filtered value
  function automatic logic signed [OUT_BITS-1:0] filter_sample(
    input logic signed [SAMPLE_BITS-1:0] x
  );
    longint acc;
    longint y;
    for (int i = TAPS - 1; i > 0; i--) sample_hist[i] = sample_hist[i - 1];
    sample_hist[0] = x;
    acc = 0;
    y = 0;
    if (mode == MODE_NOTCH) begin
      acc = (longint'(sample_hist[0]) + longint'(sample_hist[2])) * UNITY
            - NOTCH_ZERO * longint'(sample_hist[1])
            + NOTCH_POLE * longint'(y1)
            - NOTCH_DAMP * longint'(y2);
      y = (acc + HALF_LSB) >>> 16;
    end else if (mode == MODE_FIR) begin
      for (int i = 0; i < TAPS && i < LOWPASS_LEN; i++) begin
        acc += longint'(LOWPASS_COEF[i]) * longint'(sample_hist[i]);
      end
      y = (acc + HALF_LSB) >>> 16;
    end
    if (y > OUT_HI) y = OUT_HI;
    if (y < OUT_LO) y = OUT_LO;
    y2 = y1;
    y1 = OUT_BITS'(y);
    return OUT_BITS'(y);
  endfunction

  always @(posedge clk) begin : track
    logic signed [OUT_BITS-1:0] want;
    if (rst) begin
      for (int i = 0; i < TAPS; i++) sample_hist[i] = '0;
      y1 = '0;
      y2 = '0;
      mode = MODE_NOTCH;
      predicted_samples.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (predicted_samples.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transaction, expected none, got %0d",
                   $time, res.sample_out);
        end else begin
          want = predicted_samples.pop_front();
          if (res.sample_out !== want) begin
            mismatch_count++;
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want, res.sample_out);
          end
        end
      end
      if (cfg.valid && cfg.ready) mode = cfg.filter_mode;
      if (smp.valid && smp.ready) predicted_samples.push_back(filter_sample(smp.sample_in));
    end
    waiting_count <= predicted_samples.size();
  end

endmodule

/* verif/notch_or_fir_lowpass_filter_top_tb.sv */
module notch_or_fir_lowpass_filter_top_tb;
  import nfl_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk;
  logic rst;
  logic res_ready = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   failures;
  int   outstanding;

  nfl_in_if  smp ();
  nfl_out_if res ();
  nfl_cfg_if cfg ();

  assign res.ready = res_ready;

  notch_or_fir_lowpass_filter_top dut (
    .clk (clk),
    .rst (rst),
    .smp (smp),
    .res (res),
    .cfg (cfg)
  );

  notch_or_fir_lowpass_filter_check filter_check (
    .clk         (clk),
    .rst         (rst),
    .smp         (smp),
    .res         (res),
    .cfg         (cfg),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    smp.valid     <= 1'b1;
    smp.sample_in <= v;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    smp.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [MODE_BITS-1:0] m);
    wait_drained();
    cfg.valid       <= 1'b1;
    cfg.filter_mode <= m;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // 0: full-scale square tone, 1: small values, else wide random with extremes
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
    input int style,
    input int n,
    input int period
  );
    logic signed [SAMPLE_BITS-1:0] v;
    if (style == 0) begin
      v = ((n / period) % 2 != 0) ? SAMPLE_MIN : SAMPLE_MAX;
    end else if (style == 1) begin
      v = SAMPLE_BITS'(int'($urandom_range(1023)) - 512);
    end else begin
      case ($urandom_range(7))
        0: v = SAMPLE_MAX;
        1: v = SAMPLE_MIN;
        default: v = SAMPLE_BITS'($urandom);
      endcase
    end
    return v;
  endfunction

  initial begin
    int count;
    int style;
    int period;
    logic [MODE_BITS-1:0] m;
    rst             <= 1'b1;
    smp.valid       <= 1'b0;
    smp.sample_in   <= '0;
    cfg.valid       <= 1'b0;
    cfg.filter_mode <= MODE_NOTCH;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes in every mode, histories carried across mode changes
    set_mode(MODE_NOTCH);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(SAMPLE_BITS'(-1));
    send_sample(SAMPLE_BITS'(1));
    set_mode(MODE_FIR);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(SAMPLE_BITS'(1));
    send_sample(SAMPLE_BITS'(-1));
    set_mode(MODE_NONE);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    set_mode(MODE_SPARE);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    set_mode(MODE_NOTCH);
    send_sample('0);
    send_sample('0);
    send_sample('0);

    // random segments under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        if (seg < 4) m = MODE_BITS'((seg + phase) % 4);
        else m = MODE_BITS'($urandom_range(3));
        if ($urandom_range(3) != 0) set_mode(m);
        style  = $urandom_range(3);
        period = $urandom_range(2, 40);
        count  = $urandom_range(15, 40);
        for (int n = 0; n < count; n++) begin
          send_sample(pick_sample(style, n, period));
          if (phase == 1 && seg == 2 && n == count / 2) wait_drained();
        end
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
